// File: design/fcnp_pkg.sv
package fcnp_pkg;

  localparam int MAX_SETS     = 256;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_BITS    = 48;
  localparam int MAX_PREFETCH = 8;

  localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int IB_MAX   = $clog2(MAX_SETS);
  localparam int CFG_BITS = 4;
  localparam int IDX_BITS = 8;
  localparam int CNT_BITS = 32;

  localparam logic [IDX_BITS-1:0] REG_OFFSET_BITS    = 8'd0;
  localparam logic [IDX_BITS-1:0] REG_INDEX_BITS     = 8'd1;
  localparam logic [IDX_BITS-1:0] REG_WAYS_IN_USE    = 8'd2;
  localparam logic [IDX_BITS-1:0] REG_PREFETCH_DEPTH = 8'd3;

  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [ADDR_BITS-1:0] addr;
  } in_t;

  typedef struct packed {
    logic                hit;
    logic                demand_read;
    logic                mem_write;
    logic [3:0]          prefetch_reads;
    logic [CNT_BITS-1:0] total_hits;
    logic [CNT_BITS-1:0] total_misses;
    logic [CNT_BITS-1:0] total_reads;
    logic [CNT_BITS-1:0] total_writes;
  } out_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tags;
    logic [MAX_WAYS-1:0]                valid;
  } row_t;

  typedef struct packed {
    logic load;
    logic look;
    logic check;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic demand;
    logic last;
  } sts_t;

endpackage

// File: design/fifo_cache_next_line_prefetch_top.sv
// Set-associative tag store with FIFO replacement, write-through accounting
// and next-line prefetch.
// An item (op, addr) is taken on in_data at a clock edge where start is high
// and busy is low. Each item returns one result on out_data, marked by
// out_valid for exactly one cycle; the receiver cannot stall it.
// Each block lookup has two steps: the first reads the set's row from the tag
// memory, the second compares the tags and, on a miss, writes the updated row
// back. A hit ends with the demand lookup; a miss goes on to depth further
// blocks, where depth is the prefetch depth in use (at most 8), each in turn
// through the single port of the tag memory.
// The result appears in the cycle in which busy falls, so the next item can be
// accepted while the result is shown.
// Configuration writes on cfg_we/cfg_index/cfg_wdata take effect at once; the
// user must make them while the block is idle; the block does not enforce it.
// Unknown indexes are ignored. Reset (rst_n low, synchronous) clears the
// totals, restores the register defaults and marks every set empty through
// one flag per set, so no clearing pass is needed and it is ready at once.
module fifo_cache_next_line_prefetch_top
  import fcnp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  input  logic                start,
  input  in_t                 in_data,
  output logic                busy,
  output logic                out_valid,
  output out_t                out_data
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences demand and prefetch lookups.
  fcnp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // The datapath holds the tag memory, the address walk and the totals.
  fcnp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// File: design/fcnp_ctrl.sv
module fcnp_ctrl
  import fcnp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic out_valid
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_LOOK  = 3'b010,
    S_CHECK = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        // A demand hit or the last block ends the item; else walk on.
        if ((sts.found && sts.demand) || sts.last) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: design/fcnp_dp.sv
module fcnp_dp
  import fcnp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  input  in_t                 in_data,
  input  cmd_t                cmd,
  output sts_t                sts,
  output out_t                out_data
);

  logic [CFG_BITS-1:0] off_r, ib_r, ways_r, depth_r;
  logic [ADDR_BITS-1:0] pa_r;
  logic                 op_r, demand_r, hit_r;
  logic [3:0]           cnt_r, pref_r;
  logic [CNT_BITS-1:0]  hits_r, misses_r, reads_r, writes_r;

  row_t                 mem [MAX_SETS];
  logic [MAX_SETS-1:0]  row_init_r;
  row_t                 rd_row_r;
  logic                 rd_init_r;

  logic [CFG_BITS-1:0]  ib_eff, ways_eff, depth_eff;
  logic [ADDR_BITS-1:0] blk, tag;
  logic [SET_W-1:0]     set, set_mask;
  logic [MAX_WAYS-1:0]  cur_valid, in_use;
  logic                 found, slot_found;
  row_t                 new_row;
  logic                 do_write;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= 4'd6;
      ib_r    <= 4'd4;
      ways_r  <= 4'd1;
      depth_r <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_BITS:    off_r   <= cfg_wdata;
        REG_INDEX_BITS:     ib_r    <= cfg_wdata;
        REG_WAYS_IN_USE:    ways_r  <= cfg_wdata;
        REG_PREFETCH_DEPTH: depth_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    ib_eff    = (ib_r > CFG_BITS'(IB_MAX)) ? CFG_BITS'(IB_MAX) : ib_r;
    ways_eff  = (ways_r == '0) ? CFG_BITS'(1) :
                (ways_r > CFG_BITS'(MAX_WAYS)) ? CFG_BITS'(MAX_WAYS) : ways_r;
    depth_eff = (depth_r > CFG_BITS'(MAX_PREFETCH)) ? CFG_BITS'(MAX_PREFETCH) : depth_r;
    blk       = pa_r >> off_r;
    set_mask  = SET_W'((({{SET_W{1'b0}}, 1'b1}) << ib_eff) - 1'b1);
    set       = blk[SET_W-1:0] & set_mask;
    tag       = blk >> ib_eff;
  end

  // Tag compare over the ways in use, then FIFO fill or shift on a miss.
  always_comb begin
    cur_valid  = rd_init_r ? rd_row_r.valid : '0;
    found      = 1'b0;
    slot_found = 1'b0;
    new_row    = rd_row_r;
    new_row.valid = cur_valid;
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = (i < int'(ways_eff));
      if (in_use[i] && cur_valid[i] && (rd_row_r.tags[i] == tag)) found = 1'b1;
    end
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (!slot_found && in_use[i] && !cur_valid[i]) begin
        slot_found        = 1'b1;
        new_row.tags[i]   = tag;
        new_row.valid[i]  = 1'b1;
      end
    end
    if (!slot_found) begin
      for (int i = 0; i < MAX_WAYS; i++) begin
        if (i + 1 < int'(ways_eff)) new_row.tags[i] = rd_row_r.tags[i+1];
        else if (i + 1 == int'(ways_eff)) new_row.tags[i] = tag;
      end
    end
    do_write = cmd.check && !found;
  end

  always_ff @(posedge clk) begin
    if (cmd.look) rd_row_r <= mem[set];
    if (do_write) mem[set] <= new_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_init_r <= '0;
    end else if (do_write) begin
      row_init_r[set] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.look) rd_init_r <= row_init_r[set];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pa_r     <= in_data.addr;
      op_r     <= in_data.op;
      demand_r <= 1'b1;
      cnt_r    <= '0;
      pref_r   <= '0;
      hit_r    <= 1'b0;
    end else if (cmd.check) begin
      if (demand_r) hit_r <= found;
      else if (!found) pref_r <= pref_r + 4'd1;
      if (cmd.advance) begin
        pa_r     <= pa_r + (ADDR_BITS'(1) << off_r);
        cnt_r    <= cnt_r + 4'd1;
        demand_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r   <= '0;
      misses_r <= '0;
      reads_r  <= '0;
      writes_r <= '0;
    end else begin
      if (cmd.load && (in_data.op == OP_WRITE)) writes_r <= writes_r + 1'b1;
      if (cmd.check) begin
        if (demand_r && found) hits_r <= hits_r + 1'b1;
        if (demand_r && !found) misses_r <= misses_r + 1'b1;
        if (!found) reads_r <= reads_r + 1'b1;
      end
    end
  end

  assign sts.found  = found;
  assign sts.demand = demand_r;
  assign sts.last   = (cnt_r == depth_eff);

  always_comb begin
    out_data.hit            = hit_r;
    out_data.demand_read    = !hit_r;
    out_data.mem_write      = op_r;
    out_data.prefetch_reads = pref_r;
    out_data.total_hits     = hits_r;
    out_data.total_misses   = misses_r;
    out_data.total_reads    = reads_r;
    out_data.total_writes   = writes_r;
  end

endmodule

// File: design/fcnp_checker.sv
module fcnp_checker
  import fcnp_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input out_t out_data
);

  a_strobe_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid)) else $error("accepted item not in work");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  a_hit_no_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |-> (!out_data.demand_read && out_data.prefetch_reads == 4'd0))
    else $error("hit reported memory reads");

endmodule

bind fifo_cache_next_line_prefetch_top fcnp_checker u_fcnp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// File: test/fcnp_checker.sv
`timescale 1ns / 100ps

module fcnp_scoreboard
  import fcnp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  input  logic                start,
  input  logic                busy,
  input  in_t                 in_data,
  input  logic                out_valid,
  input  out_t                out_data,
  output int                  fail_count,
  output int                  pending_count,
  output int                  result_count
);

  logic [ADDR_BITS-1:0] tag_mem [MAX_SETS][MAX_WAYS];
  logic                 tag_ok  [MAX_SETS][MAX_WAYS];
  logic [31:0] hits_q, misses_q, reads_q, writes_q;
  logic [3:0]  offs_q, idx_q, ways_q, depth_q;
  out_t        expected_q[$];

  assign pending_count = expected_q.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic int eff_ib();
    return (idx_q > IB_MAX) ? IB_MAX : idx_q;
  endfunction

  function automatic int eff_ways();
    int w;
    w = (ways_q == 0) ? 1 : ways_q;
    return (w > MAX_WAYS) ? MAX_WAYS : w;
  endfunction

  function automatic void split_addr(input logic [ADDR_BITS-1:0] a, output int s,
                                     output logic [ADDR_BITS-1:0] t);
    logic [ADDR_BITS-1:0] blk;
    blk = a >> offs_q;
    s = int'(blk & ((48'd1 << eff_ib()) - 48'd1));
    t = blk >> eff_ib();
  endfunction

  function automatic bit lookup_block(input int s, input logic [ADDR_BITS-1:0] t);
    for (int i = 0; i < eff_ways(); i++)
      if (tag_ok[s][i] && tag_mem[s][i] == t) return 1;
    return 0;
  endfunction

  function automatic void fill_block(input int s, input logic [ADDR_BITS-1:0] t);
    int w;
    w = eff_ways();
    for (int i = 0; i < w; i++)
      if (!tag_ok[s][i]) begin
        tag_mem[s][i] = t;
        tag_ok[s][i] = 1'b1;
        return;
      end
    for (int i = 0; i + 1 < w; i++) tag_mem[s][i] = tag_mem[s][i+1];
    tag_mem[s][w-1] = t;
  endfunction

  function automatic out_t access_cache(input in_t it);
    out_t r;
    int s, d;
    logic [ADDR_BITS-1:0] t, pa;
    logic [3:0] pref;
    pref = '0;
    if (it.op == OP_WRITE) writes_q++;
    split_addr(it.addr, s, t);
    r.hit = lookup_block(s, t);
    if (r.hit) hits_q++;
    else begin
      misses_q++;
      reads_q++;
      fill_block(s, t);
      d = (depth_q > MAX_PREFETCH) ? MAX_PREFETCH : depth_q;
      pa = it.addr;
      for (int i = 0; i < d; i++) begin
        pa = pa + (48'd1 << offs_q);
        split_addr(pa, s, t);
        if (!lookup_block(s, t)) begin
          fill_block(s, t);
          reads_q++;
          pref++;
        end
      end
    end
    r.demand_read = !r.hit;
    r.mem_write = it.op;
    r.prefetch_reads = pref;
    r.total_hits = hits_q;
    r.total_misses = misses_q;
    r.total_reads = reads_q;
    r.total_writes = writes_q;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      for (int s = 0; s < MAX_SETS; s++)
        for (int w = 0; w < MAX_WAYS; w++) tag_ok[s][w] = 1'b0;
      {hits_q, misses_q, reads_q, writes_q} = '0;
      offs_q = 4'd6; idx_q = 4'd4; ways_q = 4'd1; depth_q = 4'd1;
      expected_q.delete();
    end else begin
      // The result shown in this cycle belongs to an item already accepted.
      if (out_valid) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $display("%0t result with no item outstanding", $realtime);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_data.hit !== e.hit) report_mismatch("hit", out_data.hit, e.hit);
          if (out_data.demand_read !== e.demand_read)
            report_mismatch("demand_read", out_data.demand_read, e.demand_read);
          if (out_data.mem_write !== e.mem_write)
            report_mismatch("mem_write", out_data.mem_write, e.mem_write);
          if (out_data.prefetch_reads !== e.prefetch_reads)
            report_mismatch("prefetch_reads", out_data.prefetch_reads, e.prefetch_reads);
          if (out_data.total_hits !== e.total_hits)
            report_mismatch("total_hits", out_data.total_hits, e.total_hits);
          if (out_data.total_misses !== e.total_misses)
            report_mismatch("total_misses", out_data.total_misses, e.total_misses);
          if (out_data.total_reads !== e.total_reads)
            report_mismatch("total_reads", out_data.total_reads, e.total_reads);
          if (out_data.total_writes !== e.total_writes)
            report_mismatch("total_writes", out_data.total_writes, e.total_writes);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET_BITS:    offs_q = cfg_wdata;
          REG_INDEX_BITS:     idx_q = cfg_wdata;
          REG_WAYS_IN_USE:    ways_q = cfg_wdata;
          REG_PREFETCH_DEPTH: depth_q = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) expected_q.push_back(access_cache(in_data));
    end
  end

  initial begin
    fail_count = 0;
    result_count = 0;
  end

endmodule

// File: test/tb_fifo_cache_next_line_prefetch_top.sv
`timescale 1ns / 100ps

module tb_fifo_cache_next_line_prefetch_top
  import fcnp_pkg::*;
();

  logic                clk, rst_n, cfg_we, start, busy, out_valid;
  logic [IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_wdata;
  in_t                 in_data;
  out_t                out_data;
  int                  fail_count, pending_count, result_count;
  int                  cycle_count;
  int                  sent_count;

  // The hold-off the sender applies, in percent; the receiver cannot stall.
  int                  idle_pct;

  // A stream base for well-formed sequential runs; the stride is random.
  logic [ADDR_BITS-1:0] run_addr;

  fifo_cache_next_line_prefetch_top u_top (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .start, .in_data,
    .busy, .out_valid, .out_data
  );

  fcnp_scoreboard u_chk (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .start, .busy, .in_data,
    .out_valid, .out_data, .fail_count, .pending_count, .result_count
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // The cycle limit covers 1460 items at the slowest miss with idle gaps, many
  // times over.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("[fifo_cache_next_line_prefetch_top] ERROR");
      $finish;
    end
  end

  // Offers one item and keeps start high until it is taken and the block is idle
  // again; start is left high, and a later hold-off or drain drops it.
  task automatic send_item(input logic op, input logic [ADDR_BITS-1:0] a);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_data <= '{op: op, addr: a};
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  // Waits out every outstanding result plus the worst miss latency, so that a
  // register write sees an idle block.
  task automatic drain;
    start <= 0;
    @(posedge clk);
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  // Each write drops the enable again and waits with it low before returning,
  // so back-to-back writes never merge into one long enable pulse.
  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input int ob, input int ib, input int w, input int d);
    drain();
    write_reg(REG_OFFSET_BITS, CFG_BITS'(ob));
    write_reg(REG_INDEX_BITS, CFG_BITS'(ib));
    write_reg(REG_WAYS_IN_USE, CFG_BITS'(w));
    write_reg(REG_PREFETCH_DEPTH, CFG_BITS'(d));
  endtask

  // Most random items are short sequential runs that walk blocks, hit and
  // thrash sets; the rest are full-range noise addresses.
  task automatic random_items(input int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      if (k < 3) run_addr = ADDR_BITS'({$urandom, $urandom});
      else if (k < 7)
        run_addr = run_addr + ADDR_BITS'($urandom_range(3) << $urandom_range(12));
      else if (k < 9)
        run_addr = run_addr ^ ADDR_BITS'($urandom_range(1) << $urandom_range(20));
      send_item(1'($urandom_range(1)), run_addr);
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    start = 0;
    in_data = '0;
    idle_pct = 0;
    cycle_count = 0;
    sent_count = 0;
    run_addr = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part at reset geometry: address extremes, both ops, repeat hit,
    // and a prefetch that wraps past the top of the address space.
    send_item(1'b0, '0);
    send_item(1'b1, '0);
    send_item(1'b1, '1);
    send_item(1'b0, 48'h0000_0000_0040);
    send_item(1'b0, 48'hAAAA_AAAA_AAAA);
    send_item(1'b1, 48'h5555_5555_5555);
    // Odd way count, deep prefetch beyond the maximum, oversized index and
    // offset fields, and a write to a register index that does not exist.
    set_geometry(15, 15, 3, 15);
    write_reg(8'hFF, 4'hF);
    send_item(1'b0, '1);
    send_item(1'b1, 48'h8000_0000_0000);
    send_item(1'b0, 48'h0000_0000_0000);
    // Zero ways, zero prefetch, zero offset and index: a single-block cache.
    set_geometry(0, 0, 0, 0);
    send_item(1'b0, 48'h1);
    send_item(1'b0, 48'h1);
    send_item(1'b1, 48'h2);
    // Eight ways with a shrink afterwards: stale valid ways must be ignored.
    set_geometry(4, 2, 8, 8);
    for (int i = 0; i < 6; i++) send_item(i[0], ADDR_BITS'(i) * 48'h40);
    set_geometry(4, 2, 1, 2);
    send_item(1'b0, 48'h40);
    send_item(1'b0, 48'h0);

    // Random phases over several geometries and idling mixes.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 49;
        2: idle_pct = 27;
        default: idle_pct = 0;
      endcase
      if (ph == 11) set_geometry(12, 8, 8, 8);
      else if (ph == 10) set_geometry(0, 0, 1, 0);
      else set_geometry($urandom_range(12), $urandom_range(8),
                        1 << $urandom_range(3), $urandom_range(8));
      random_items(120);
    end

    drain();
    $display("Sent %0d items, checked %0d results over a dozen cache geometries",
             sent_count, result_count);
    $display("with sequential runs, noise addresses and sender gaps of 0, 27 and 49 percent.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("[fifo_cache_next_line_prefetch_top] OK");
    end else begin
      $display("[fifo_cache_next_line_prefetch_top] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
design/fcnp_pkg.sv
design/fcnp_ctrl.sv
design/fcnp_dp.sv
design/fifo_cache_next_line_prefetch_top.sv
design/fcnp_checker.sv
test/fcnp_checker.sv
test/tb_fifo_cache_next_line_prefetch_top.sv
